// File: rtl/core/lpl_pkg.sv
// lpl_pkg: types, register codes and fixed-point constants of the peak limiter
// no dependencies; used by lookahead_peak_limiter
package lpl_pkg;

   // field widths
   localparam int SAMPLE_W   = 16;
   localparam int GAIN_W     = 17;
   localparam int COEFF_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   // shared shift-add multiplier: radix-4, one 2-bit digit per cycle
   localparam int MUL_W = 20;
   localparam int CNT_W = 4;
   localparam logic [CNT_W-1:0] DIV_LAST = 4'd15;  // 16 quotient bits
   localparam logic [CNT_W-1:0] MUL_LAST = 4'd7;   // 8 digits of 16 bits

   // gain constants, Q1.16
   localparam logic [GAIN_W-1:0] GAIN_UNITY      = 17'd65536;
   localparam logic [GAIN_W-1:0] GAIN_NEAR_UNITY = 17'd65471;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE   = 3'd3;

   // register reset values
   localparam logic                  RST_ENABLE    = 1'b1;
   localparam logic [GAIN_W-1:0]     RST_THRESHOLD = 17'd65536;
   localparam logic [COEFF_W-1:0]    RST_ATTACK    = 16'd58982;
   localparam logic [COEFF_W-1:0]    RST_RELEASE   = 16'd65529;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_in;
      logic                       block_end;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       block_active;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_PREP,
      ST_SMOOTH,
      ST_SCALE,
      ST_DONE
   } lpl_state_type;

endpackage

// File: rtl/core/lpl_ram.sv
// lpl_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module lpl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/lookahead_peak_limiter.sv
// lookahead_peak_limiter: look-ahead peak limiter with ring delay line and smoothed gain
// depends on lpl_pkg and lpl_ram
//
//   channel  ports                          dir  payload
//   req      req_valid/req_ready/req_data   in   sample_in, block_end
//   rsp      rsp_valid/rsp_ready/rsp_data   out  sample_out, block_active
//   csr      csr_valid/csr_ready            in   csr_index, csr_wdata
//
// one item at a time: enabled, the sample is loaded, run through the bit-serial divider
// (one quotient bit per cycle) only when it exceeds the threshold, then through two passes of
// the shared radix-4 shift-add multiplier; disabled, it goes straight to the hand-off state.
// reset leaves the delay line uncleared: a fill flag returns zero until the write
// pointer has wrapped once, so there is no clearing pass and the block is ready at once.
// a stalled result waits in the output register while the next item is taken.
module lookahead_peak_limiter #(
   parameter int LOOKAHEAD_DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  lpl_pkg::req_payload_type              req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output lpl_pkg::rsp_payload_type              rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lpl_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [lpl_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int PTR_W = $clog2(LOOKAHEAD_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(LOOKAHEAD_DEPTH - 1);

   // control state
   lpl_pkg::lpl_state_type              state_ff, state_in;
   logic                                enable_ff, enable_in;
   logic [lpl_pkg::GAIN_W-1:0]          thr_ff, thr_in;
   logic [lpl_pkg::COEFF_W-1:0]         attack_ff, attack_in;
   logic [lpl_pkg::COEFF_W-1:0]         release_ff, release_in;
   logic [PTR_W-1:0]                    ptr_ff, ptr_in;
   logic                                filled_ff, filled_in;
   logic [lpl_pkg::GAIN_W-1:0]          gain_ff, gain_in;
   logic                                seen_ff, seen_in;
   logic                                rsp_valid_ff, rsp_valid_in;

   // datapath
   logic signed [lpl_pkg::SAMPLE_W-1:0] x_ff, x_in;
   logic                                last_ff, last_in;
   logic signed [lpl_pkg::SAMPLE_W-1:0] d_ff, d_in;
   logic [lpl_pkg::GAIN_W-1:0]          absx_ff, absx_in;
   logic                                limited_ff, limited_in;
   logic [lpl_pkg::GAIN_W-1:0]          rem_ff, rem_in;
   logic [lpl_pkg::GAIN_W-1:0]          target_ff, target_in;
   logic                                falling_ff, falling_in;
   logic signed [lpl_pkg::MUL_W-1:0]    mcand_ff, mcand_in;
   logic [lpl_pkg::COEFF_W-1:0]         mplier_ff, mplier_in;
   logic signed [lpl_pkg::MUL_W-1:0]    acc_ff, acc_in;
   logic [lpl_pkg::CNT_W-1:0]           cnt_ff, cnt_in;
   lpl_pkg::rsp_payload_type            res_ff, res_in;
   lpl_pkg::rsp_payload_type            rsp_data_ff, rsp_data_in;

   // combinational helpers
   logic                                csr_write;
   logic [lpl_pkg::SAMPLE_W-1:0]        x_mag;
   logic [lpl_pkg::GAIN_W-1:0]          absx_now;
   logic [lpl_pkg::GAIN_W:0]            rem_dbl;
   logic [lpl_pkg::GAIN_W:0]            rem_sub;
   logic                                div_bit;
   logic signed [lpl_pkg::MUL_W-1:0]    addend0, addend1, step_sum, acc_step;
   logic [lpl_pkg::GAIN_W-1:0]          dist_part;
   logic [lpl_pkg::GAIN_W-1:0]          gain_calc, gain_next;
   logic                                tgt_below;
   logic [lpl_pkg::GAIN_W-1:0]          dist_now;
   logic                                ram_wr_en;
   logic [lpl_pkg::SAMPLE_W-1:0]        ram_rd_data;

   // delay line
   lpl_ram #(
      .WIDTH (lpl_pkg::SAMPLE_W),
      .DEPTH (LOOKAHEAD_DEPTH)
   ) u_delay (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ptr_ff),
      .wr_data (x_ff),
      .rd_addr (ptr_ff),
      .rd_data (ram_rd_data)
   );

   assign csr_write = csr_valid && csr_ready;
   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == lpl_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // 2*|x| in Q1.16, up to unity
   assign x_mag    = x_ff[lpl_pkg::SAMPLE_W-1] ? lpl_pkg::SAMPLE_W'(-x_ff) : x_ff;
   assign absx_now = {x_mag, 1'b0};

   // restoring divider step, one quotient bit
   assign rem_dbl = {rem_ff, 1'b0};
   assign rem_sub = rem_dbl - {1'b0, absx_ff};
   assign div_bit = (rem_dbl >= {1'b0, absx_ff});

   // radix-4 shift-add step, low digit first, result floor(a*m / 2^16) after 8 steps
   assign addend0  = mplier_ff[0] ? mcand_ff : '0;
   assign addend1  = mplier_ff[1] ? (mcand_ff <<< 1) : '0;
   assign step_sum = acc_ff + addend0 + addend1;
   assign acc_step = step_sum >>> 2;

   // smoother update from the truncated distance product
   assign dist_part = acc_step[lpl_pkg::GAIN_W-1:0];
   assign gain_calc = falling_ff ? (target_ff + dist_part) : (target_ff - dist_part);
   assign gain_next = (!falling_ff && gain_calc >= lpl_pkg::GAIN_NEAR_UNITY) ?
                      lpl_pkg::GAIN_UNITY : gain_calc;

   // attack when the target lies below the current gain
   assign tgt_below = (target_ff < gain_ff);
   assign dist_now  = tgt_below ? (gain_ff - target_ff) : (target_ff - gain_ff);

   // next state and datapath
   always_comb begin
      state_in     = state_ff;
      enable_in    = enable_ff;
      thr_in       = thr_ff;
      attack_in    = attack_ff;
      release_in   = release_ff;
      ptr_in       = ptr_ff;
      filled_in    = filled_ff;
      gain_in      = gain_ff;
      seen_in      = seen_ff;
      rsp_valid_in = rsp_valid_ff;
      x_in         = x_ff;
      last_in      = last_ff;
      d_in         = d_ff;
      absx_in      = absx_ff;
      limited_in   = limited_ff;
      rem_in       = rem_ff;
      target_in    = target_ff;
      falling_in   = falling_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      ram_wr_en    = 1'b0;

      // output register drains on transfer
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         lpl_pkg::ST_IDLE: begin
            if (req_valid) begin
               x_in    = req_data.sample_in;
               last_in = req_data.block_end;
               if (enable_ff) begin
                  state_in = lpl_pkg::ST_LOAD;
               end else begin
                  res_in.sample_out   = req_data.sample_in;
                  res_in.block_active = 1'b0;
                  state_in            = lpl_pkg::ST_DONE;
               end
            end
         end
         lpl_pkg::ST_LOAD: begin
            // oldest sample out, new sample in
            d_in       = filled_ff ? $signed(ram_rd_data) : '0;
            ram_wr_en  = 1'b1;
            ptr_in     = (ptr_ff == PTR_LAST) ? '0 : ptr_ff + 1'b1;
            filled_in  = filled_ff || (ptr_ff == PTR_LAST);
            absx_in    = absx_now;
            limited_in = (absx_now > thr_ff);
            rem_in     = thr_ff;
            cnt_in     = '0;
            if (absx_now > thr_ff) begin
               target_in = '0;
               state_in  = lpl_pkg::ST_DIV;
            end else begin
               target_in = lpl_pkg::GAIN_UNITY;
               state_in  = lpl_pkg::ST_PREP;
            end
         end
         lpl_pkg::ST_DIV: begin
            // target = threshold * 2^16 / (2*|x|)
            rem_in    = div_bit ? rem_sub[lpl_pkg::GAIN_W-1:0] : rem_dbl[lpl_pkg::GAIN_W-1:0];
            target_in = {target_ff[lpl_pkg::GAIN_W-2:0], div_bit};
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == lpl_pkg::DIV_LAST) begin
               state_in = lpl_pkg::ST_PREP;
            end
         end
         lpl_pkg::ST_PREP: begin
            falling_in = tgt_below;
            mcand_in   = {3'b000, dist_now};
            mplier_in  = tgt_below ? attack_ff : release_ff;
            acc_in     = '0;
            cnt_in     = '0;
            state_in   = lpl_pkg::ST_SMOOTH;
         end
         lpl_pkg::ST_SMOOTH: begin
            acc_in    = acc_step;
            mplier_in = mplier_ff >> 2;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == lpl_pkg::MUL_LAST) begin
               gain_in   = gain_next;
               mcand_in  = {{4{d_ff[lpl_pkg::SAMPLE_W-1]}}, d_ff};
               mplier_in = gain_next[lpl_pkg::COEFF_W-1:0];
               acc_in    = '0;
               cnt_in    = '0;
               state_in  = lpl_pkg::ST_SCALE;
            end
         end
         lpl_pkg::ST_SCALE: begin
            acc_in    = acc_step;
            mplier_in = mplier_ff >> 2;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == lpl_pkg::MUL_LAST) begin
               // unity gain passes the delayed sample as it is
               res_in.sample_out = gain_ff[lpl_pkg::GAIN_W-1] ?
                                   d_ff : acc_step[lpl_pkg::SAMPLE_W-1:0];
               res_in.block_active = last_ff &&
                  (seen_ff || limited_ff || gain_ff < lpl_pkg::GAIN_NEAR_UNITY);
               seen_in  = last_ff ? 1'b0 : (seen_ff || limited_ff);
               state_in = lpl_pkg::ST_DONE;
            end
         end
         lpl_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = lpl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lpl_pkg::ST_IDLE;
         end
      endcase

      // register writes
      if (csr_write) begin
         case (csr_index)
            lpl_pkg::CSR_ENABLE: begin
               enable_in = csr_wdata[0];
               if (!csr_wdata[0]) begin
                  ptr_in    = '0;
                  filled_in = 1'b0;
                  gain_in   = lpl_pkg::GAIN_UNITY;
                  seen_in   = 1'b0;
               end
            end
            lpl_pkg::CSR_THRESHOLD: thr_in     = csr_wdata;
            lpl_pkg::CSR_ATTACK:    attack_in  = csr_wdata[lpl_pkg::COEFF_W-1:0];
            lpl_pkg::CSR_RELEASE:   release_in = csr_wdata[lpl_pkg::COEFF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lpl_pkg::ST_IDLE;
         enable_ff    <= lpl_pkg::RST_ENABLE;
         thr_ff       <= lpl_pkg::RST_THRESHOLD;
         attack_ff    <= lpl_pkg::RST_ATTACK;
         release_ff   <= lpl_pkg::RST_RELEASE;
         ptr_ff       <= '0;
         filled_ff    <= 1'b0;
         gain_ff      <= lpl_pkg::GAIN_UNITY;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enable_ff    <= enable_in;
         thr_ff       <= thr_in;
         attack_ff    <= attack_in;
         release_ff   <= release_in;
         ptr_ff       <= ptr_in;
         filled_ff    <= filled_in;
         gain_ff      <= gain_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      last_ff     <= last_in;
      d_ff        <= d_in;
      absx_ff     <= absx_in;
      limited_ff  <= limited_in;
      rem_ff      <= rem_in;
      target_ff   <= target_in;
      falling_ff  <= falling_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      acc_ff      <= acc_in;
      cnt_ff      <= cnt_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // gain never rises above unity
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      gain_ff <= lpl_pkg::GAIN_UNITY)
      else $error("smoothed gain above unity");

   // a disable write restores unity gain and an empty delay line
   a_disable_clears: assert property (@(posedge clock) disable iff (reset)
      (csr_write && csr_index == lpl_pkg::CSR_ENABLE && !csr_wdata[0]) |=>
      (gain_ff == lpl_pkg::GAIN_UNITY && ptr_ff == '0 && !filled_ff && !seen_ff))
      else $error("disable write left state behind");

   // the divider runs only for a limiting sample
   a_div_limited: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lpl_pkg::ST_DIV) |-> limited_ff)
      else $error("division without limiting");

   // a limiting target stays below unity
   a_target_below: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lpl_pkg::ST_PREP && limited_ff) |-> (target_ff < lpl_pkg::GAIN_UNITY))
      else $error("limiting target not below unity");

   // a result appears only from the hand-off state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == lpl_pkg::ST_DONE))
      else $error("result register loaded outside hand-off");

endmodule

// File: bench/testbench.sv
// testbench: self-checking bench for lookahead_peak_limiter
// holds its own gain and delay-line predictor in a small scoreboard class
// depends on lpl_pkg and the limiter rtl
`timescale 1ns / 1ps

module testbench;

   localparam int LOOKAHEAD_DEPTH = 64;
   localparam int CYCLE_LIMIT     = 300000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 40;
   localparam int MAX_GAP         = 12;

   // indexes past the register list, writes there are ignored
   localparam logic [lpl_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd4;
   localparam logic [lpl_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   // scoreboard: limiter predictor and queue of expected output samples
   class limiter_scoreboard;
      bit                                  enabled;
      bit [lpl_pkg::GAIN_W-1:0]            threshold;
      bit [lpl_pkg::COEFF_W-1:0]           att_coeff;
      bit [lpl_pkg::COEFF_W-1:0]           rel_coeff;
      logic signed [lpl_pkg::SAMPLE_W-1:0] delay_line [LOOKAHEAD_DEPTH];
      int unsigned                         wr_ptr;
      bit [lpl_pkg::GAIN_W-1:0]            gain;
      bit                                  seen_limit;
      lpl_pkg::rsp_payload_type            expected_q [$];
      int unsigned                         errors;

      function new();
         enabled   = lpl_pkg::RST_ENABLE;
         threshold = lpl_pkg::RST_THRESHOLD;
         att_coeff = lpl_pkg::RST_ATTACK;
         rel_coeff = lpl_pkg::RST_RELEASE;
         errors    = 0;
         clear_state();
      endfunction

      function void clear_state();
         foreach (delay_line[i]) delay_line[i] = '0;
         wr_ptr     = 0;
         gain       = lpl_pkg::GAIN_UNITY;
         seen_limit = 1'b0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // register write, values masked to the register width
      function void note_csr(logic [lpl_pkg::CSR_IDX_W-1:0] index,
                             logic [lpl_pkg::CSR_DATA_W-1:0] data);
         case (index)
            lpl_pkg::CSR_ENABLE: begin
               enabled = data[0];
               if (!enabled) clear_state();
            end
            lpl_pkg::CSR_THRESHOLD: threshold = data[lpl_pkg::GAIN_W-1:0];
            lpl_pkg::CSR_ATTACK:    att_coeff = data[lpl_pkg::COEFF_W-1:0];
            lpl_pkg::CSR_RELEASE:   rel_coeff = data[lpl_pkg::COEFF_W-1:0];
            default: ;
         endcase
      endfunction

      // one-pole step toward the target, distance product truncated
      function bit [lpl_pkg::GAIN_W-1:0] glide(longint unsigned g, longint unsigned tgt,
                                               longint unsigned c);
         longint unsigned gap;
         if (g >= tgt) begin
            gap = ((g - tgt) * c) >> 16;
            return lpl_pkg::GAIN_W'(tgt + gap);
         end
         gap = ((tgt - g) * c) >> 16;
         return lpl_pkg::GAIN_W'(tgt - gap);
      endfunction

      // accepted input transfer: advance the predictor and queue the result
      function void note_request(lpl_pkg::req_payload_type item);
         lpl_pkg::rsp_payload_type            exp;
         logic signed [lpl_pkg::SAMPLE_W-1:0] oldest;
         longint                              sx;
         longint unsigned                     mag;
         longint unsigned                     tgt;
         longint                              prod;
         longint                              scaled;
         bit                                  limited;
         if (!enabled) begin
            exp.sample_out   = item.sample_in;
            exp.block_active = 1'b0;
            expected_q.push_back(exp);
            return;
         end
         // delay line read-then-write
         oldest           = delay_line[wr_ptr];
         delay_line[wr_ptr] = item.sample_in;
         wr_ptr           = (wr_ptr + 1) % LOOKAHEAD_DEPTH;
         // target gain from the new sample
         sx      = longint'($signed(item.sample_in));
         mag     = longint'(sx < 0 ? -sx : sx) * 2;
         tgt     = lpl_pkg::GAIN_UNITY;
         limited = 1'b0;
         if (mag > threshold) begin
            tgt     = (longint'(threshold) << 16) / mag;
            limited = 1'b1;
         end
         // attack when falling, release with snap to unity otherwise
         if (tgt < gain) begin
            gain = glide(gain, tgt, att_coeff);
         end else begin
            gain = glide(gain, tgt, rel_coeff);
            if (gain >= lpl_pkg::GAIN_NEAR_UNITY) gain = lpl_pkg::GAIN_UNITY;
         end
         // scale the delayed sample, floor towards minus infinity
         prod   = longint'($signed(oldest)) * longint'(gain);
         scaled = prod >>> 16;
         exp.sample_out = scaled[lpl_pkg::SAMPLE_W-1:0];
         // per-block limiting flag
         if (item.block_end) begin
            exp.block_active = seen_limit || limited || (gain < lpl_pkg::GAIN_NEAR_UNITY);
            seen_limit = 1'b0;
         end else begin
            exp.block_active = 1'b0;
            if (limited) seen_limit = 1'b1;
         end
         expected_q.push_back(exp);
      endfunction

      // accepted output transfer against the oldest expectation
      function void check_response(lpl_pkg::rsp_payload_type got);
         lpl_pkg::rsp_payload_type exp;
         if (expected_q.size() == 0) begin
            errors++;
            $error("rsp transfer with nothing expected: sample_out %0d block_active %0d",
                   $signed(got.sample_out), got.block_active);
            return;
         end
         exp = expected_q.pop_front();
         if (got.sample_out !== exp.sample_out) begin
            errors++;
            $error("sample_out: expected %0d, got %0d",
                   $signed(exp.sample_out), $signed(got.sample_out));
         end
         if (got.block_active !== exp.block_active) begin
            errors++;
            $error("block_active: expected %0d, got %0d", exp.block_active, got.block_active);
         end
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   lpl_pkg::req_payload_type       req_data;
   logic                           rsp_valid;
   logic                           rsp_ready;
   lpl_pkg::rsp_payload_type       rsp_data;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [lpl_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [lpl_pkg::CSR_DATA_W-1:0] csr_wdata;

   limiter_scoreboard sb;
   int                send_idle_pct  = 0;
   int                recv_stall_pct = 0;
   logic              hold_off_req   = 1'b0;
   int unsigned       cycle_count    = 0;

   lookahead_peak_limiter #(.LOOKAHEAD_DEPTH(LOOKAHEAD_DEPTH)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic bit roll(int pct);
      return int'($urandom_range(99, 0)) < pct;
   endfunction

   // result side: random stalls, plus a long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ready = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else if (roll(recv_stall_pct)) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(MAX_GAP, 1)) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
            @(negedge clock);
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) sb.check_response(rsp_data);
   end

   // one input transfer, with random idle ahead of it; leaves valid high
   task automatic send_request(input logic signed [lpl_pkg::SAMPLE_W-1:0] value,
                               input logic last);
      lpl_pkg::req_payload_type item;
      item.sample_in = value;
      item.block_end = last;
      while (roll(send_idle_pct)) begin
         req_valid = 1'b0;
         repeat ($urandom_range(MAX_GAP, 1)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(item);
      @(negedge clock);
   endtask

   // sender stops until every expected result has come back
   task automatic wait_results();
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // register write, only with the block idle
   task automatic write_csr(input logic [lpl_pkg::CSR_IDX_W-1:0] index,
                            input logic [lpl_pkg::CSR_DATA_W-1:0] data);
      wait_results();
      csr_valid = 1'b1;
      csr_index = index;
      csr_wdata = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.note_csr(index, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // sample mix: extremes, loud peaks, quiet signal and full range noise
   function automatic logic signed [lpl_pkg::SAMPLE_W-1:0] pick_sample();
      logic signed [lpl_pkg::SAMPLE_W-1:0] v;
      case ($urandom_range(9, 0))
         0: begin
            case ($urandom_range(4, 0))
               0: v = 16'h8000;
               1: v = 16'h7FFF;
               2: v = 16'h0000;
               3: v = 16'hFFFF;
               default: v = 16'h0001;
            endcase
         end
         1, 2, 3: begin
            v = lpl_pkg::SAMPLE_W'($urandom_range(32767, 16000));
            if ($urandom_range(1, 0)) v = -v;
         end
         4, 5: begin
            v = lpl_pkg::SAMPLE_W'($urandom_range(2000, 0));
            if ($urandom_range(1, 0)) v = -v;
         end
         default: v = lpl_pkg::SAMPLE_W'($urandom());
      endcase
      return v;
   endfunction

   function automatic logic [lpl_pkg::CSR_DATA_W-1:0] pick_threshold();
      case ($urandom_range(7, 0))
         0: return '0;
         1: return 17'd6554;
         2: return lpl_pkg::GAIN_UNITY;
         3: return 17'h1FFFF;
         default: return lpl_pkg::CSR_DATA_W'($urandom_range(65536, 6554));
      endcase
   endfunction

   // coefficient with a random bit above the register width
   function automatic logic [lpl_pkg::CSR_DATA_W-1:0] pick_coeff();
      logic [lpl_pkg::COEFF_W-1:0] c;
      case ($urandom_range(5, 0))
         0: c = '0;
         1: c = '1;
         default: c = lpl_pkg::COEFF_W'($urandom());
      endcase
      return {1'($urandom_range(1, 0)), c};
   endfunction

   task automatic new_settings();
      write_csr(lpl_pkg::CSR_THRESHOLD, pick_threshold());
      write_csr(lpl_pkg::CSR_ATTACK, pick_coeff());
      write_csr(lpl_pkg::CSR_RELEASE, pick_coeff());
   endtask

   // one register change between blocks, with a short pass-through burst on disable
   task automatic retune();
      case ($urandom_range(4, 0))
         0: begin
            write_csr(lpl_pkg::CSR_ENABLE, {16'($urandom()), 1'b0});
            repeat ($urandom_range(4, 1)) send_request(pick_sample(), 1'($urandom_range(1, 0)));
            write_csr(lpl_pkg::CSR_ENABLE, {16'($urandom()), 1'b1});
         end
         1: write_csr(lpl_pkg::CSR_THRESHOLD, pick_threshold());
         2: write_csr(lpl_pkg::CSR_ATTACK, pick_coeff());
         3: write_csr(lpl_pkg::CSR_RELEASE, pick_coeff());
         default: write_csr(lpl_pkg::CSR_IDX_W'($urandom_range(CSR_SPARE_HI, CSR_SPARE_LO)),
                            lpl_pkg::CSR_DATA_W'($urandom()));
      endcase
   endtask

   // directed corners
   task automatic run_directed();
      // reset settings, full scale does not exceed unity threshold
      send_request(16'h0000, 1'b0);
      send_request(16'h7FFF, 1'b0);
      send_request(16'h8000, 1'b1);
      // half threshold, fast attack, slowest release
      write_csr(lpl_pkg::CSR_THRESHOLD, 17'd32768);
      write_csr(lpl_pkg::CSR_ATTACK, 17'd32768);
      write_csr(lpl_pkg::CSR_RELEASE, 17'd65535);
      send_request(16'h7FFF, 1'b0);
      send_request(16'h8000, 1'b0);
      send_request(16'h0001, 1'b0);
      send_request(16'hFFFF, 1'b1);
      // zero threshold: any nonzero sample limits to target zero
      write_csr(lpl_pkg::CSR_THRESHOLD, '0);
      send_request(16'h0000, 1'b0);
      send_request(16'h0001, 1'b0);
      send_request(16'hFFFF, 1'b1);
      // threshold above unity never limits
      write_csr(lpl_pkg::CSR_THRESHOLD, 17'h1FFFF);
      send_request(16'h8000, 1'b1);
      send_request(16'h7FFF, 1'b0);
      // zero coefficients jump straight to the target
      write_csr(lpl_pkg::CSR_THRESHOLD, 17'd6554);
      write_csr(lpl_pkg::CSR_ATTACK, '0);
      write_csr(lpl_pkg::CSR_RELEASE, '0);
      send_request(16'sd20000, 1'b0);
      send_request(16'h0000, 1'b1);
      // slowest attack and release
      write_csr(lpl_pkg::CSR_ATTACK, 17'd65535);
      write_csr(lpl_pkg::CSR_RELEASE, 17'd65535);
      send_request(16'h8000, 1'b0);
      send_request(16'sd12345, 1'b1);
      // disable clears state, a second disable clears again
      write_csr(lpl_pkg::CSR_ENABLE, '0);
      send_request(16'h8000, 1'b1);
      send_request(16'h7FFF, 1'b0);
      write_csr(lpl_pkg::CSR_ENABLE, '0);
      send_request(16'sd5, 1'b1);
      write_csr(lpl_pkg::CSR_ENABLE, 17'd1);
      // writes past the register list
      write_csr(CSR_SPARE_LO, 17'h1FFFF);
      write_csr(CSR_SPARE_HI, 17'h0AAAA);
      // back to reset settings
      write_csr(lpl_pkg::CSR_THRESHOLD, lpl_pkg::RST_THRESHOLD);
      write_csr(lpl_pkg::CSR_ATTACK, {1'b0, lpl_pkg::RST_ATTACK});
      write_csr(lpl_pkg::CSR_RELEASE, {1'b0, lpl_pkg::RST_RELEASE});
   endtask

   // mostly well-formed blocks of random length, some with stray block ends
   task automatic run_random_phase(input int items);
      int  sent;
      int  len;
      bit  noisy;
      sent = 0;
      while (sent < items) begin
         if (roll(6)) retune();
         len   = $urandom_range(16, 1);
         noisy = roll(10);
         for (int i = 0; i < len; i++) begin
            send_request(pick_sample(),
                         noisy ? 1'($urandom_range(1, 0)) : (i == len - 1));
         end
         sent += len;
      end
   endtask

   // main sequence
   initial begin
      sb        = new();
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = lpl_pkg::CSR_ENABLE;
      csr_wdata = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // no idling
      run_directed();
      run_random_phase(100);

      // sender idle most of the time
      wait_results();
      send_idle_pct = 74;
      new_settings();
      run_random_phase(100);

      // receiver stalls, opening with a long hold-off that backs up the input
      wait_results();
      send_idle_pct  = 0;
      recv_stall_pct = 74;
      new_settings();
      hold_off_req = 1'b1;
      repeat (12) send_request(pick_sample(), 1'($urandom_range(1, 0)));
      run_random_phase(100);

      // light idling on both sides
      wait_results();
      send_idle_pct  = 8;
      recv_stall_pct = 8;
      new_settings();
      run_random_phase(100);

      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
